// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers for the frame parser
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define LFP_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication
`define LFP_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  `LFP_ASSERT(name, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ===== hdl/lfp_pkg.sv =====
// ----------------------------------------------------------------------------
// lfp_pkg
// types, constants and crc helper for the link frame parser
// ----------------------------------------------------------------------------
`default_nettype none

package lfp_pkg;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_GOOD    = 2'd1;
  localparam logic [1:0] KIND_BAD     = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN     = 2'd2;

  // register reset values
  localparam logic [7:0]  SYNC_FIRST_RST  = 8'hA5;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'h5A;
  localparam logic [15:0] MAX_LEN_RST     = 16'd220;

  // crc-16/ccitt-false
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] max_len;
  } lfp_cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [15:0] index;
    logic [7:0]  ftype;
    logic [15:0] flen;
  } lfp_result_t;

  // one byte through the crc, msb first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/lfp_parser.sv =====
// ----------------------------------------------------------------------------
// lfp_parser
// frame state machine, header capture and running crc, one byte per step
// ----------------------------------------------------------------------------
`default_nettype none

module lfp_parser
  import lfp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire lfp_cfg_t    cfg_i,
  input  wire logic        step_i,
  input  wire logic [7:0]  byte_i,
  output logic             res_valid_o,
  output lfp_result_t      res_o
);

  typedef enum logic [7:0] {
    ST_HUNT    = 8'b0000_0001,
    ST_SYNC2   = 8'b0000_0010,
    ST_TYPE    = 8'b0000_0100,
    ST_LEN_LO  = 8'b0000_1000,
    ST_LEN_HI  = 8'b0001_0000,
    ST_PAYLOAD = 8'b0010_0000,
    ST_CRC_LO  = 8'b0100_0000,
    ST_CRC_HI  = 8'b1000_0000
  } lfp_state_e;

  lfp_state_e  state_q, state_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] len_q, len_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [15:0] idx_q, idx_d;

  logic [15:0] crc_upd;
  logic [15:0] idx_inc;
  logic [15:0] len_new;

  assign crc_upd = crc16_byte(crc_q, byte_i);
  assign idx_inc = idx_q + 16'd1;
  assign len_new = {byte_i, len_q[7:0]};

  // next state and result for the byte at the input
  always_comb begin
    state_d     = state_q;
    type_d      = type_q;
    len_d       = len_q;
    crc_d       = crc_q;
    crc_lo_d    = crc_lo_q;
    idx_d       = idx_q;
    res_valid_o = 1'b0;
    res_o.kind  = KIND_PAYLOAD;
    res_o.data  = 8'h00;
    res_o.index = 16'h0000;
    res_o.ftype = type_q;
    res_o.flen  = len_q;
    unique case (state_q)
      ST_HUNT: begin
        if (byte_i == cfg_i.sync_first) begin
          state_d = ST_SYNC2;
        end
      end
      ST_SYNC2: begin
        state_d = (byte_i == cfg_i.sync_second) ? ST_TYPE : ST_HUNT;
      end
      ST_TYPE: begin
        type_d  = byte_i;
        crc_d   = crc16_byte(CRC_INIT, byte_i);
        state_d = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        len_d   = {8'h00, byte_i};
        crc_d   = crc_upd;
        state_d = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        len_d = len_new;
        crc_d = crc_upd;
        idx_d = 16'h0000;
        priority if (len_new > cfg_i.max_len) begin
          state_d = ST_HUNT;
        end else if (len_new == 16'h0000) begin
          state_d = ST_CRC_LO;
        end else begin
          state_d = ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        res_valid_o = 1'b1;
        res_o.data  = byte_i;
        res_o.index = idx_q;
        crc_d       = crc_upd;
        idx_d       = idx_inc;
        if (idx_inc == len_q) begin
          state_d = ST_CRC_LO;
        end
      end
      ST_CRC_LO: begin
        crc_lo_d = byte_i;
        state_d  = ST_CRC_HI;
      end
      ST_CRC_HI: begin
        res_valid_o = 1'b1;
        res_o.kind  = ({byte_i, crc_lo_q} == crc_q) ? KIND_GOOD : KIND_BAD;
        crc_d       = CRC_INIT;
        state_d     = ST_HUNT;
      end
      default: begin
        state_d = ST_HUNT;
      end
    endcase
  end

  // parser state, advanced only when the byte is consumed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_HUNT;
      type_q   <= 8'h00;
      len_q    <= 16'h0000;
      crc_q    <= CRC_INIT;
      crc_lo_q <= 8'h00;
      idx_q    <= 16'h0000;
    end else if (step_i) begin
      state_q  <= state_d;
      type_q   <= type_d;
      len_q    <= len_d;
      crc_q    <= crc_d;
      crc_lo_q <= crc_lo_d;
      idx_q    <= idx_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/link_frame_parser_crc16.sv =====
// ----------------------------------------------------------------------------
// link_frame_parser_crc16
// length-prefixed link frame parser with crc-16/ccitt-false check
// ----------------------------------------------------------------------------
// Takes one received byte per cycle and emits each payload byte with its index,
// then a good or bad verdict on the second crc byte; a word is accepted every
// cycle as long as the output side keeps up. Each byte passes an input
// register, a combinational parse and byte-wide crc update, and an output
// register. Bytes that produce no result never wait on the output side.
// Configuration is written through a plain write port; the user must write it
// only while no frame data is in flight, and the block does not enforce this.
`default_nettype none

`include "assert_macros.svh"

module link_frame_parser_crc16
  import lfp_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // input channel
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [7:0]            rx_byte_i,
  // output channel
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [1:0]                 out_kind_o,
  output logic [7:0]                 out_byte_o,
  output logic [15:0]                byte_index_o,
  output logic [7:0]                 frame_type_o,
  output logic [15:0]                frame_len_o
);

  lfp_cfg_t    cfg_q;
  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_byte_q;
  logic        in_take;
  logic        out_free;
  logic        step;
  logic        res_valid;
  lfp_result_t res;
  logic        out_load;
  logic        out_valid_q, out_valid_d;
  lfp_result_t out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first  <= SYNC_FIRST_RST;
      cfg_q.sync_second <= SYNC_SECOND_RST;
      cfg_q.max_len     <= MAX_LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SYNC_FIRST:  cfg_q.sync_first  <= cfg_wdata_i[7:0];
        CFG_SYNC_SECOND: cfg_q.sync_second <= cfg_wdata_i[7:0];
        CFG_MAX_LEN:     cfg_q.max_len     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // handshake: the held word moves on unless it needs a busy output slot
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && (!res_valid || out_free);
  assign in_stall_o = in_valid_q && !step;
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_load   = step && res_valid;

  // input register
  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // parser
  lfp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // output register
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_kind_o   = out_q.kind;
  assign out_byte_o   = out_q.data;
  assign byte_index_o = out_q.index;
  assign frame_type_o = out_q.ftype;
  assign frame_len_o  = out_q.flen;

  // checks
  `LFP_ASSERT_IMPL(a_kind_legal, clk_i, rst_ni, out_valid_o, out_kind_o == KIND_PAYLOAD || out_kind_o == KIND_GOOD || out_kind_o == KIND_BAD, "illegal result kind")
  `LFP_ASSERT_IMPL(a_verdict_zero, clk_i, rst_ni, out_valid_o && out_kind_o != KIND_PAYLOAD, out_byte_o == 8'h00 && byte_index_o == 16'h0000, "verdict carries payload data")
  `LFP_ASSERT_IMPL(a_index_in_frame, clk_i, rst_ni, out_valid_o && out_kind_o == KIND_PAYLOAD, byte_index_o < frame_len_o, "payload index beyond frame length")
  `LFP_ASSERT_IMPL(a_load_when_free, clk_i, rst_ni, out_load, out_free, "result overwrites pending word")

endmodule

`default_nettype wire
